FILE: hdl/hhv_pkg.sv
// Shared constants and types for the HTTP host validator.
// Used by hhv_scan and http_host_validator_core; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package hhv_pkg;

    // Longest host string examined; longer strings give the too-long verdict.
    localparam int MAX_HOST_LEN = 1024;
    // Position counter saturates at MAX_HOST_LEN + 1.
    localparam int POS_W = $clog2(MAX_HOST_LEN + 2);
    // Fixed width of the host_length result field.
    localparam int LEN_W = 11;

    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_HOST_LEN);
    localparam logic [POS_W-1:0] POS_OVER  = POS_W'(MAX_HOST_LEN + 1);

    // Characters of interest.
    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_SLASH    = 8'h2F;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_Z  = 8'h5A;

    typedef enum logic [1:0] {
        MODE_USUAL   = 2'd0,
        MODE_LITERAL = 2'd1,
        MODE_REST    = 2'd2
    } scan_mode_t;

    typedef enum logic [1:0] {
        VERDICT_OK       = 2'd0,
        VERDICT_DECLINED = 2'd1,
        VERDICT_TOO_LONG = 2'd2
    } verdict_t;

    typedef struct packed {
        verdict_t         verdict;
        logic [LEN_W-1:0] host_length;
        logic             needs_copy;
    } result_t;

endpackage

`default_nettype wire

FILE: hdl/hhv_scan.sv
// Per-byte scan state of the host validator and the verdict logic.
// Depends on hhv_pkg; instantiated by http_host_validator_core.
`timescale 1ns / 1ps
`default_nettype none

module hhv_scan
    import hhv_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       byte_take,
    input  wire logic [7:0] host_byte,
    input  wire logic       last_byte,
    input  wire logic       force_copy,
    output logic            result_fire,
    output result_t         result
);

    logic [POS_W-1:0] byte_position_reg, byte_position_next;
    logic [POS_W-1:0] last_dot_position_reg, last_dot_position_next;
    logic             dot_seen_reg, dot_seen_next;
    scan_mode_t       scan_mode_reg, scan_mode_next;
    logic [POS_W-1:0] cut_length_reg, cut_length_next;
    logic             cut_taken_reg, cut_taken_next;
    logic             rejected_reg, rejected_next;
    logic             upper_seen_reg, upper_seen_next;

    // Updated state after this byte, before the end-of-string clear
    logic [POS_W-1:0] pos_upd;
    logic [POS_W-1:0] dot_upd;
    logic             dot_seen_upd;
    scan_mode_t       mode_upd;
    logic [POS_W-1:0] cut_upd;
    logic             cut_taken_upd;
    logic             rejected_upd;
    logic             upper_upd;
    logic [POS_W-1:0] part_len;

    // Examine one byte against the scan state
    always_comb
    begin
        pos_upd       = byte_position_reg;
        dot_upd       = last_dot_position_reg;
        dot_seen_upd  = dot_seen_reg;
        mode_upd      = scan_mode_reg;
        cut_upd       = cut_length_reg;
        cut_taken_upd = cut_taken_reg;
        rejected_upd  = rejected_reg;
        upper_upd     = upper_seen_reg;

        if (byte_position_reg < POS_LIMIT)
        begin
            pos_upd = byte_position_reg + 1'b1;
            if (!rejected_reg)
            begin
                case (host_byte)
                    CH_DOT:
                    begin
                        if (dot_seen_reg && byte_position_reg != '0 &&
                            last_dot_position_reg == byte_position_reg - 1'b1)
                        begin
                            rejected_upd = 1'b1;
                        end
                        else
                        begin
                            dot_upd      = byte_position_reg;
                            dot_seen_upd = 1'b1;
                        end
                    end
                    CH_COLON:
                    begin
                        if (scan_mode_reg == MODE_USUAL)
                        begin
                            cut_upd       = byte_position_reg;
                            cut_taken_upd = 1'b1;
                            mode_upd      = MODE_REST;
                        end
                    end
                    CH_LBRACKET:
                    begin
                        if (byte_position_reg == '0)
                        begin
                            mode_upd = MODE_LITERAL;
                        end
                    end
                    CH_RBRACKET:
                    begin
                        if (scan_mode_reg == MODE_LITERAL)
                        begin
                            cut_upd       = byte_position_reg + 1'b1;
                            cut_taken_upd = 1'b1;
                            mode_upd      = MODE_REST;
                        end
                    end
                    CH_NUL, CH_SLASH:
                    begin
                        rejected_upd = 1'b1;
                    end
                    default:
                    begin
                        if (host_byte inside {[CH_UPPER_A:CH_UPPER_Z]})
                        begin
                            upper_upd = 1'b1;
                        end
                    end
                endcase
            end
        end
        else
        begin
            pos_upd = POS_OVER;
        end
    end

    // Form the verdict from the updated state
    always_comb
    begin
        part_len = cut_taken_upd ? cut_upd : pos_upd;
        if (dot_seen_upd && part_len != '0 && dot_upd == part_len - 1'b1)
        begin
            part_len = part_len - 1'b1;
        end

        result.verdict     = VERDICT_OK;
        result.host_length = '0;
        result.needs_copy  = 1'b0;
        if (pos_upd > POS_LIMIT)
        begin
            result.verdict = VERDICT_TOO_LONG;
        end
        else if (rejected_upd || part_len == '0)
        begin
            result.verdict = VERDICT_DECLINED;
        end
        else
        begin
            result.host_length = LEN_W'(part_len);
            result.needs_copy  = upper_upd | force_copy;
        end
    end

    assign result_fire = byte_take & last_byte;

    // Advance on each taken byte; clear after the final byte
    always_comb
    begin
        byte_position_next     = byte_position_reg;
        last_dot_position_next = last_dot_position_reg;
        dot_seen_next          = dot_seen_reg;
        scan_mode_next         = scan_mode_reg;
        cut_length_next        = cut_length_reg;
        cut_taken_next         = cut_taken_reg;
        rejected_next          = rejected_reg;
        upper_seen_next        = upper_seen_reg;
        if (byte_take)
        begin
            if (last_byte)
            begin
                byte_position_next     = '0;
                last_dot_position_next = '0;
                dot_seen_next          = 1'b0;
                scan_mode_next         = MODE_USUAL;
                cut_length_next        = '0;
                cut_taken_next         = 1'b0;
                rejected_next          = 1'b0;
                upper_seen_next        = 1'b0;
            end
            else
            begin
                byte_position_next     = pos_upd;
                last_dot_position_next = dot_upd;
                dot_seen_next          = dot_seen_upd;
                scan_mode_next         = mode_upd;
                cut_length_next        = cut_upd;
                cut_taken_next         = cut_taken_upd;
                rejected_next          = rejected_upd;
                upper_seen_next        = upper_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg     <= '0;
            last_dot_position_reg <= '0;
            dot_seen_reg          <= 1'b0;
            scan_mode_reg         <= MODE_USUAL;
            cut_length_reg        <= '0;
            cut_taken_reg         <= 1'b0;
            rejected_reg          <= 1'b0;
            upper_seen_reg        <= 1'b0;
        end
        else
        begin
            byte_position_reg     <= byte_position_next;
            last_dot_position_reg <= last_dot_position_next;
            dot_seen_reg          <= dot_seen_next;
            scan_mode_reg         <= scan_mode_next;
            cut_length_reg        <= cut_length_next;
            cut_taken_reg         <= cut_taken_next;
            rejected_reg          <= rejected_next;
            upper_seen_reg        <= upper_seen_next;
        end
    end

    // Position never runs past the saturation value
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_position_reg <= POS_OVER)
        else $error("byte position beyond saturation");

    // A recorded dot always lies before the current position
    assert property (@(posedge clk) disable iff (!rst_n)
        dot_seen_reg |-> last_dot_position_reg < byte_position_reg)
        else $error("dot position not behind byte position");

    // Once the host part is cut, the rest of the string is only scanned
    assert property (@(posedge clk) disable iff (!rst_n)
        cut_taken_reg |-> scan_mode_reg == MODE_REST)
        else $error("cut taken outside rest mode");

endmodule

`default_nettype wire

FILE: hdl/http_host_validator_core.sv
// Top level of the HTTP host validator: scan unit plus output buffering.
// Depends on hhv_pkg and hhv_scan.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   Input channel: one host character per transaction on host_byte, with
//   last_byte high on the final character. A transaction completes when
//   in_valid is high and in_stall is low.
//   Output channel: one transaction per host string, issued after its final
//   byte: verdict, host_length and needs_copy, completing when out_valid is
//   high and out_stall is low.
//   Configuration: cfg_write_en writes cfg_write_data into the
//   force-lowercase-copy bit; change it only while no string is in flight.
//   Throughput: one byte per cycle while in_stall is low; the scan state
//   update and verdict logic are combinational ahead of the output register.
//   Result path: the verdict of the final byte is registered in the output
//   register, or in the skid register while the output is stalled.
//   Stall: a two-entry output buffer (output register plus skid register)
//   lets input keep flowing while one result waits; in_stall rises only
//   when both entries hold results.
//   Reset: clears scan state, empties the output buffer and clears the
//   configuration bit.

module http_host_validator_core
    import hhv_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic [7:0]       host_byte,
    input  wire logic             last_byte,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic [1:0]            verdict,
    output logic [LEN_W-1:0]      host_length,
    output logic                  needs_copy,
    input  wire logic             cfg_write_en,
    input  wire logic             cfg_write_data
);

    logic    force_copy_reg;
    logic    byte_take;
    logic    result_fire;
    result_t result;
    result_t out_data_reg;
    logic    out_valid_reg, out_valid_next;
    result_t skid_data_reg;
    logic    skid_valid_reg, skid_valid_next;
    logic    out_take;
    logic    load_out;
    logic    load_skid;

    assign byte_take = in_valid & ~in_stall;
    assign in_stall  = skid_valid_reg;
    assign out_take  = out_valid_reg & ~out_stall;

    // Hold the configuration bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            force_copy_reg <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            force_copy_reg <= cfg_write_data;
        end
    end

    hhv_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_take   (byte_take),
        .host_byte   (host_byte),
        .last_byte   (last_byte),
        .force_copy  (force_copy_reg),
        .result_fire (result_fire),
        .result      (result)
    );

    // Steer a new result into the output register or the skid register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_out        = 1'b0;
        load_skid       = 1'b0;
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                load_out        = 1'b1;
                skid_valid_next = 1'b0;
            end
        end
        else if (result_fire)
        begin
            if (!out_valid_reg || out_take)
            begin
                load_out       = 1'b1;
                out_valid_next = 1'b1;
            end
            else
            begin
                load_skid       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : result;
        end
        if (load_skid)
        begin
            skid_data_reg <= result;
        end
    end

    assign out_valid   = out_valid_reg;
    assign verdict     = out_data_reg.verdict;
    assign host_length = out_data_reg.host_length;
    assign needs_copy  = out_data_reg.needs_copy;

    // The skid entry is only ever filled behind a full output register
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

    // The skid entry fills only when the output was stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && out_stall))
        else $error("skid entry filled without a stall");

    // No verdict code outside the defined set
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (verdict == VERDICT_OK || verdict == VERDICT_DECLINED ||
                           verdict == VERDICT_TOO_LONG))
        else $error("undefined verdict code");

    // A non-accepting verdict carries no length and no copy request
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && verdict != VERDICT_OK) |-> (host_length == '0 && !needs_copy))
        else $error("rejected host carries length or copy flag");

endmodule

`default_nettype wire

FILE: sim/http_host_validator_core_tb.sv
// Self-checking testbench for http_host_validator_core: directed hosts, then random hosts.
// Depends on hhv_pkg and the validator RTL; a scan model predicts all unpinned verdicts.
`timescale 1ns / 1ps

module http_host_validator_core_tb;

    import hhv_pkg::*;

    localparam int STUCK_LIMIT = 5000;
    localparam int N_CASES     = 23;

    typedef struct {
        logic [7:0] ch;
        logic       fin;
        bit         pinned;
        result_t    want;
    } host_item_t;

    typedef struct {
        string    text;
        int       fill;     // count of 'a' bytes appended to text
        int       nul_at;   // position overwritten with NUL, -1 for none
        bit       copy_on;  // force-lowercase-copy setting for this host
        bit       pinned;   // use the verdict typed below
        verdict_t v;
        int       len;
        bit       copy;
    } host_case_t;

    logic             clk;
    logic             rst_n          = 1'b0;
    logic             in_valid       = 1'b0;
    logic [7:0]       host_byte      = 8'h00;
    logic             last_byte      = 1'b0;
    logic             out_stall      = 1'b0;
    logic             cfg_write_en   = 1'b0;
    logic             cfg_write_data = 1'b0;
    logic             in_stall;
    logic             out_valid;
    logic [1:0]       verdict;
    logic [LEN_W-1:0] host_length;
    logic             needs_copy;

    wire in_fire  = in_valid && !in_stall;
    wire out_fire = out_valid && !out_stall;

    host_item_t char_q[$];
    result_t    verdict_q[$];
    int         fail_count = 0;
    int         stuck_cycles = 0;
    bit         quiet = 1'b0;

    // Scan model state
    int         scan_pos = 0;
    int         dot_pos = 0;
    bit         dot_seen = 1'b0;
    scan_mode_t scan_mode = MODE_USUAL;
    int         cut_len = 0;
    bit         cut_taken = 1'b0;
    bit         declined = 1'b0;
    bit         upper_seen = 1'b0;
    bit         force_copy = 1'b0;

    host_case_t dir_cases [N_CASES] = '{
        '{"example.com", 0,    -1, 1'b0, 1'b1, VERDICT_OK,       11,   1'b0},
        '{"Example.COM", 0,    -1, 1'b0, 1'b1, VERDICT_OK,       11,   1'b1},
        '{"a..b",        0,    -1, 1'b0, 1'b1, VERDICT_DECLINED, 0,    1'b0},
        '{"a/b",         0,    -1, 1'b0, 1'b1, VERDICT_DECLINED, 0,    1'b0},
        '{"ab",          0,     1, 1'b0, 1'b1, VERDICT_DECLINED, 0,    1'b0},
        '{".",           0,    -1, 1'b0, 1'b1, VERDICT_DECLINED, 0,    1'b0},
        '{":80",         0,    -1, 1'b0, 1'b1, VERDICT_DECLINED, 0,    1'b0},
        '{"host.",       0,    -1, 1'b0, 1'b0, VERDICT_OK,       0,    1'b0},
        '{"host.:80",    0,    -1, 1'b0, 1'b0, VERDICT_OK,       0,    1'b0},
        '{"host.:8.0",   0,    -1, 1'b0, 1'b0, VERDICT_OK,       0,    1'b0},
        '{"[::1]:443",   0,    -1, 1'b0, 1'b0, VERDICT_OK,       0,    1'b0},
        '{"[::1",        0,    -1, 1'b0, 1'b0, VERDICT_OK,       0,    1'b0},
        '{"a[b]",        0,    -1, 1'b0, 1'b0, VERDICT_OK,       0,    1'b0},
        '{"[]",          0,    -1, 1'b0, 1'b0, VERDICT_OK,       0,    1'b0},
        '{"a/..Zq",      0,    -1, 1'b0, 1'b1, VERDICT_DECLINED, 0,    1'b0},
        '{"a",           1023, -1, 1'b0, 1'b1, VERDICT_OK,       1024, 1'b0},
        '{"a",           1024, -1, 1'b0, 1'b1, VERDICT_TOO_LONG, 0,    1'b0},
        '{"a/",          1023, -1, 1'b0, 1'b1, VERDICT_TOO_LONG, 0,    1'b0},
        '{"\377\200~",   0,    -1, 1'b0, 1'b0, VERDICT_OK,       0,    1'b0},
        '{"example.com", 0,    -1, 1'b1, 1'b1, VERDICT_OK,       11,   1'b1},
        '{"a..b",        0,    -1, 1'b1, 1'b1, VERDICT_DECLINED, 0,    1'b0},
        '{"A[b",         0,    -1, 1'b1, 1'b0, VERDICT_OK,       0,    1'b0},
        '{"x",           0,    -1, 1'b0, 1'b1, VERDICT_OK,       1,    1'b0}
    };

    http_host_validator_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .host_byte      (host_byte),
        .last_byte      (last_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .verdict        (verdict),
        .host_length    (host_length),
        .needs_copy     (needs_copy),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Advance the scan model by one host byte; report the verdict on the final byte
    task automatic scan_host_byte(input logic [7:0] ch, input logic fin,
                                  output bit done, output result_t res);
        int hlen;
        done = 1'b0;
        res  = '0;
        if (scan_pos < MAX_HOST_LEN)
        begin
            if (!declined)
            begin
                case (ch)
                    CH_DOT:
                        if (dot_seen && scan_pos > 0 && dot_pos == scan_pos - 1)
                            declined = 1'b1;
                        else
                        begin
                            dot_pos  = scan_pos;
                            dot_seen = 1'b1;
                        end
                    CH_COLON:
                        if (scan_mode == MODE_USUAL)
                        begin
                            cut_len   = scan_pos;
                            cut_taken = 1'b1;
                            scan_mode = MODE_REST;
                        end
                    CH_LBRACKET:
                        if (scan_pos == 0)
                            scan_mode = MODE_LITERAL;
                    CH_RBRACKET:
                        if (scan_mode == MODE_LITERAL)
                        begin
                            cut_len   = scan_pos + 1;
                            cut_taken = 1'b1;
                            scan_mode = MODE_REST;
                        end
                    CH_NUL, CH_SLASH:
                        declined = 1'b1;
                    default:
                        if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z)
                            upper_seen = 1'b1;
                endcase
            end
            scan_pos++;
        end
        else
            scan_pos = MAX_HOST_LEN + 1;

        if (fin)
        begin
            done = 1'b1;
            if (scan_pos > MAX_HOST_LEN)
                res.verdict = VERDICT_TOO_LONG;
            else if (declined)
                res.verdict = VERDICT_DECLINED;
            else
            begin
                hlen = cut_taken ? cut_len : scan_pos;
                // Trim one trailing dot; the latest dot anywhere decides
                if (dot_seen && hlen > 0 && dot_pos == hlen - 1)
                    hlen--;
                if (hlen == 0)
                    res.verdict = VERDICT_DECLINED;
                else
                begin
                    res.verdict     = VERDICT_OK;
                    res.host_length = LEN_W'(hlen);
                    res.needs_copy  = upper_seen || force_copy;
                end
            end
            scan_pos   = 0;
            dot_pos    = 0;
            dot_seen   = 1'b0;
            scan_mode  = MODE_USUAL;
            cut_len    = 0;
            cut_taken  = 1'b0;
            declined   = 1'b0;
            upper_seen = 1'b0;
        end
    endtask

    task automatic take_byte();
        host_item_t it;
        bit         done;
        result_t    got;
        it = char_q.pop_front();
        scan_host_byte(host_byte, last_byte, done, got);
        if (done)
            verdict_q.push_back(it.pinned ? it.want : got);
    endtask

    task automatic check_result();
        result_t want;
        if (verdict_q.size() == 0)
        begin
            fail_count++;
            $display("%0t: unexpected result verdict=%0d length=%0d copy=%0d",
                     $time, verdict, host_length, needs_copy);
        end
        else
        begin
            want = verdict_q.pop_front();
            if (verdict !== want.verdict || host_length !== want.host_length ||
                needs_copy !== want.needs_copy)
            begin
                fail_count++;
                $display("%0t: mismatch: expected verdict=%0d length=%0d copy=%0d, ",
                         $time, want.verdict, want.host_length, want.needs_copy,
                         "actual verdict=%0d length=%0d copy=%0d",
                         verdict, host_length, needs_copy);
            end
        end
    endtask

    // Input side: predict accepted transactions, hold while stalled, idle at random
    always @(posedge clk)
    begin
        if (in_fire)
            take_byte();
        if (!(in_valid && in_stall))
        begin
            if (rst_n && char_q.size() > 0 && (quiet || $urandom_range(99) >= 13))
            begin
                in_valid  <= 1'b1;
                host_byte <= char_q[0].ch;
                last_byte <= char_q[0].fin;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Output side: check accepted transactions, stall at random
    always @(posedge clk)
    begin
        if (out_fire)
            check_result();
        out_stall <= rst_n && !quiet && ($urandom_range(99) < 13);
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (in_fire || out_fire)
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic void queue_host(input logic [7:0] body[$], input bit pinned,
                                       input result_t want);
        host_item_t it;
        foreach (body[i])
        begin
            it.ch     = body[i];
            it.fin    = (i == body.size() - 1);
            it.pinned = pinned;
            it.want   = want;
            char_q.push_back(it);
        end
    endfunction

    function automatic logic [7:0] label_char();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return "a" + 8'($urandom_range(25));
        else if (r < 70)
            return CH_UPPER_A + 8'($urandom_range(25));
        else if (r < 95)
            return "0" + 8'($urandom_range(9));
        else
            return "-";
    endfunction

    // Build one random host: mostly well-formed names and literals, some noise
    function automatic int queue_random_host();
        logic [7:0] body[$];
        result_t    none;
        int         kind;
        int         n;
        int         k;
        none = '0;
        kind = $urandom_range(99);
        if (kind < 1)
        begin
            n = $urandom_range(1020, 1030);
            repeat (n) body.push_back(label_char());
        end
        else if (kind < 16)
        begin
            n = $urandom_range(1, 8);
            repeat (n) body.push_back(8'($urandom_range(255)));
        end
        else if (kind < 32)
        begin
            body.push_back(CH_LBRACKET);
            n = $urandom_range(0, 6);
            repeat (n) body.push_back(($urandom_range(3) == 0) ? CH_COLON : label_char());
            if ($urandom_range(4) != 0)
                body.push_back(CH_RBRACKET);
        end
        else
        begin
            k = $urandom_range(1, 3);
            for (int i = 0; i < k; i++)
            begin
                if (i > 0)
                    body.push_back(CH_DOT);
                n = $urandom_range(1, 5);
                repeat (n) body.push_back(label_char());
            end
            if ($urandom_range(4) == 0)
                body.push_back(CH_DOT);
        end

        // Append a port, sometimes with a dot after the cut
        if ($urandom_range(4) == 0)
        begin
            body.push_back(CH_COLON);
            n = $urandom_range(0, 4);
            repeat (n) body.push_back("0" + 8'($urandom_range(9)));
            if ($urandom_range(9) == 0)
                body.push_back(CH_DOT);
        end

        // Break some hosts: a double dot or a bad byte
        if ($urandom_range(14) == 0)
        begin
            k = $urandom_range(body.size());
            body.insert(k, CH_DOT);
            body.insert(k, CH_DOT);
        end
        if ($urandom_range(19) == 0)
            body[$urandom_range(body.size() - 1)] = ($urandom_range(1) != 0) ? CH_NUL
                                                                             : CH_SLASH;
        queue_host(body, 1'b0, none);
        return body.size();
    endfunction

    // Wait until every transaction is through, plus the block's latency
    task automatic drain();
        do
            @(negedge clk);
        while (char_q.size() != 0 || in_valid || verdict_q.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_force_copy(input bit v);
        drain();
        @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        force_copy = v;
        @(negedge clk);
    endtask

    initial
    begin
        logic [7:0] body[$];
        result_t    want;
        int         rand_items;
        int         phase;
        int         n;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        set_force_copy(1'b0);

        // Walk the directed table
        foreach (dir_cases[r])
        begin
            if (dir_cases[r].copy_on != force_copy)
                set_force_copy(dir_cases[r].copy_on);
            body.delete();
            for (int i = 0; i < dir_cases[r].text.len(); i++)
                body.push_back(dir_cases[r].text[i]);
            repeat (dir_cases[r].fill) body.push_back("a");
            if (dir_cases[r].nul_at >= 0)
                body[dir_cases[r].nul_at] = CH_NUL;
            want.verdict     = dir_cases[r].v;
            want.host_length = LEN_W'(dir_cases[r].len);
            want.needs_copy  = dir_cases[r].copy;
            queue_host(body, dir_cases[r].pinned, want);
        end

        // Random phases, each with its own register setting; one phase without idling
        rand_items = 0;
        phase = 0;
        while (rand_items < 1000)
        begin
            set_force_copy(1'($urandom_range(1)));
            quiet = (phase == 2);
            n = $urandom_range(10, 30);
            repeat (n) rand_items += queue_random_host();
            phase++;
        end

        drain();
        quiet = 1'b0;
        repeat (4) @(negedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/hhv_pkg.sv
hdl/hhv_scan.sv
hdl/http_host_validator_core.sv
sim/http_host_validator_core_tb.sv
